// ===== sv/apd_pkg.sv =====
// Shared types, constants and command/status structs of the profile decimator.
package apd_pkg;

  localparam int COORD_W = 32;
  localparam int RAD_W   = 31;
  localparam int REG_W   = 31;
  localparam int FRAC_W  = 20;

  // multiplier geometry: 33-bit limbs, A up to four limbs, B up to two
  localparam int LIMB     = 33;
  localparam int A_LIMBS  = 4;
  localparam int B_LIMBS  = 2;
  localparam int A_W      = LIMB * A_LIMBS;
  localparam int B_W      = LIMB * B_LIMBS;
  localparam int ACC_W    = LIMB * (A_LIMBS + B_LIMBS);
  localparam int SQ_W     = 2 * LIMB;
  localparam int PR_W     = LIMB * A_LIMBS;

  localparam longint unsigned EPS_LEN    = ((64'd1 << FRAC_W) + 64'd500000) / 64'd1000000;
  localparam longint unsigned EPS_DUP    = ((64'd1 << FRAC_W) + 64'd5000) / 64'd10000;
  localparam longint unsigned EPS_LEN_SQ = EPS_LEN * EPS_LEN;
  localparam longint unsigned EPS_DUP_SQ = EPS_DUP * EPS_DUP;
  localparam logic [31:0]     COS2_Q32   = 32'd4284238823;

  localparam logic [REG_W-1:0] ELEMENT_SIZE_RST  = 31'd52429;
  localparam logic [REG_W-1:0] FLOOR_SPACING_RST = 31'd3146;
  localparam logic [REG_W-1:0] TIGHT_FLOOR_RST   = 31'd524;

  localparam logic [1:0] CFG_ELEMENT_SIZE  = 2'd0;
  localparam logic [1:0] CFG_FLOOR_SPACING = 2'd1;
  localparam logic [1:0] CFG_TIGHT_FLOOR   = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic [RAD_W-1:0]          rad;
  } point_t;

  typedef enum logic [2:0] {A_DELTA, A_LP2, A_DOT, A_PR, A_SP} asrc_t;
  typedef enum logic [2:0] {B_DELTA, B_LN2, B_DOT, B_COS2, B_SP} bsrc_t;
  // PO: pending-older, NP: current-pending, PK: pending-kept,
  // NF: current-first, NK: current-kept
  typedef enum logic [2:0] {D_PO, D_NP, D_PK, D_NF, D_NK} dsel_t;
  typedef enum logic [2:0] {
    WB_NONE, WB_LP2, WB_LN2, WB_POSNEG, WB_DOT2, WB_PR, WB_D2
  } wb_t;
  typedef enum logic [1:0] {E_CUR, E_PEND, E_KEPT} esrc_t;

  typedef struct packed {
    logic  load_cur;
    logic  run;
    logic  acc_add;
    asrc_t asrc;
    bsrc_t bsrc;
    dsel_t dsel_a;
    dsel_t dsel_b;
    logic  comp_rad;
    wb_t   wb;
    logic  turn_clr;
    logic  sharp_ld;
    logic  sharp_val;
    logic  emit;
    esrc_t esrc;
    logic  eop;
    logic  fail;
    logic  keep;
    logic  init_first;
    logic  shift;
    logic  fin_pending;
    logic  clear;
  } apd_cmd_t;

  typedef struct packed {
    logic [2:0] seen;
    logic [1:0] kept_cnt;
    logic       last;
    logic       mul_last;
    logic       out_free;
    logic       lp_ok;
    logic       ln_ok;
    logic       pos_lt_neg;
    logic       turn_lt;
    logic       far;
    logic       dup;
    logic       moved;
  } apd_stat_t;

endpackage

// ===== sv/apd_if.sv =====
// Request channel interfaces: input points and kept points.
interface apd_in_if import apd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_axial;
  logic signed [COORD_W-1:0] point_radius;
  logic                      last_point;

  modport source (output valid, point_axial, point_radius, last_point, input ready);
  modport sink   (input valid, point_axial, point_radius, last_point, output ready);
endinterface

interface apd_out_if import apd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] kept_axial;
  logic [RAD_W-1:0]          kept_radius;
  logic                      end_of_profile;
  logic                      failed;

  modport source (output valid, kept_axial, kept_radius, end_of_profile, failed,
                  input ready);
  modport sink   (input valid, kept_axial, kept_radius, end_of_profile, failed,
                  output ready);
endinterface

// ===== sv/adaptive_profile_decimator_top.sv =====
// Top level of the adaptive profile decimator.
//  channel  | dir | handshake       | payload
//  in_pt    | in  | valid / ready   | point_axial, point_radius, last_point
//  out_pt   | out | valid / ready   | kept_axial, kept_radius, end_of_profile, failed
//  cfg      | in  | cfg_we          | cfg_addr, cfg_wdata
// An item is only shifted in, or its predecessor is judged with the full turn test
// (which can end early); a closing point adds further checks. The 33x33 limb
// multiplier, one partial product a cycle while it runs, does this arithmetic.
// Up to two results per item leave through a one-deep output register.
// A full output register stalls only the step that emits; the next item is taken
// while a result waits. Reset (rst_n low, synchronous) restores register defaults.
module adaptive_profile_decimator_top import apd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_addr,
  input  logic [REG_W-1:0] cfg_wdata,
  apd_in_if.sink           in_pt,
  apd_out_if.source        out_pt
);

  apd_cmd_t  cmd;
  apd_stat_t stat;
  logic      in_ready;

  assign in_pt.ready = in_ready;

  apd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_pt.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  apd_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_axial   (in_pt.point_axial),
    .in_radius  (in_pt.point_radius),
    .in_last    (in_pt.last_point),
    .out_ready  (out_pt.ready),
    .out_valid  (out_pt.valid),
    .out_axial  (out_pt.kept_axial),
    .out_radius (out_pt.kept_radius),
    .out_eop    (out_pt.end_of_profile),
    .out_failed (out_pt.failed),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

// ===== sv/apd_ctrl.sv =====
// Sequencer of the decimator: steps the shared multiplier and the decisions.
module apd_ctrl import apd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  apd_stat_t stat,
  output apd_cmd_t  cmd
);

  typedef enum logic [26:0] {
    ST_IDLE  = 27'd1 << 0,
    ST_DISP  = 27'd1 << 1,
    ST_FIRST = 27'd1 << 2,
    ST_SHORT = 27'd1 << 3,
    ST_SHIFT = 27'd1 << 4,
    ST_J0    = 27'd1 << 5,
    ST_J1    = 27'd1 << 6,
    ST_J2    = 27'd1 << 7,
    ST_J3    = 27'd1 << 8,
    ST_J4    = 27'd1 << 9,
    ST_J5    = 27'd1 << 10,
    ST_J6    = 27'd1 << 11,
    ST_J7    = 27'd1 << 12,
    ST_J8    = 27'd1 << 13,
    ST_J9    = 27'd1 << 14,
    ST_J10   = 27'd1 << 15,
    ST_J11   = 27'd1 << 16,
    ST_K0    = 27'd1 << 17,
    ST_K1    = 27'd1 << 18,
    ST_K2    = 27'd1 << 19,
    ST_K3    = 27'd1 << 20,
    ST_L0    = 27'd1 << 21,
    ST_L1    = 27'd1 << 22,
    ST_L2    = 27'd1 << 23,
    ST_F0    = 27'd1 << 24,
    ST_F1    = 27'd1 << 25,
    ST_F2    = 27'd1 << 26
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_cur = 1'b1;
          state_nxt    = ST_DISP;
        end
      end
      ST_DISP: begin
        if (stat.seen == 3'd0) begin
          state_nxt = ST_FIRST;
        end else if (!stat.last) begin
          state_nxt = (stat.seen >= 3'd2) ? ST_J0 : ST_SHIFT;
        end else begin
          state_nxt = (stat.seen < 3'd3) ? ST_SHORT : ST_L0;
        end
      end
      ST_FIRST: begin
        if (stat.out_free) begin
          cmd.emit       = 1'b1;
          cmd.esrc       = E_CUR;
          cmd.eop        = stat.last;
          cmd.fail       = stat.last;
          cmd.init_first = 1'b1;
          cmd.clear      = stat.last;
          state_nxt      = ST_IDLE;
        end
      end
      ST_SHORT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.esrc  = E_KEPT;
          cmd.eop   = 1'b1;
          cmd.fail  = 1'b1;
          cmd.clear = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_SHIFT: begin
        cmd.shift = 1'b1;
        state_nxt = ST_IDLE;
      end
      // incoming leg squared length
      ST_J0: begin
        cmd.run       = 1'b1;
        cmd.dsel_a    = D_PO;
        cmd.dsel_b    = D_PO;
        cmd.turn_clr  = 1'b1;
        cmd.sharp_ld  = 1'b1;
        cmd.sharp_val = 1'b0;
        if (stat.mul_last) state_nxt = ST_J1;
      end
      ST_J1: begin
        cmd.run      = 1'b1;
        cmd.acc_add  = 1'b1;
        cmd.dsel_a   = D_PO;
        cmd.dsel_b   = D_PO;
        cmd.comp_rad = 1'b1;
        if (stat.mul_last) state_nxt = ST_J2;
      end
      ST_J2: begin
        cmd.wb     = WB_LP2;
        cmd.run    = 1'b1;
        cmd.dsel_a = D_NP;
        cmd.dsel_b = D_NP;
        if (stat.mul_last) state_nxt = ST_J3;
      end
      ST_J3: begin
        cmd.run      = 1'b1;
        cmd.acc_add  = 1'b1;
        cmd.dsel_a   = D_NP;
        cmd.dsel_b   = D_NP;
        cmd.comp_rad = 1'b1;
        if (stat.mul_last) state_nxt = ST_J4;
      end
      // dot product terms, sorted into positive and negative sums
      ST_J4: begin
        cmd.wb     = WB_LN2;
        cmd.run    = 1'b1;
        cmd.dsel_a = D_PO;
        cmd.dsel_b = D_NP;
        if (stat.mul_last) state_nxt = ST_J5;
      end
      ST_J5: begin
        cmd.wb       = WB_POSNEG;
        cmd.run      = 1'b1;
        cmd.dsel_a   = D_PO;
        cmd.dsel_b   = D_NP;
        cmd.comp_rad = 1'b1;
        if (stat.mul_last) state_nxt = ST_J6;
      end
      ST_J6: begin
        cmd.wb    = WB_POSNEG;
        state_nxt = ST_J7;
      end
      ST_J7: begin
        if (stat.lp_ok && stat.ln_ok && !stat.pos_lt_neg) begin
          cmd.run  = 1'b1;
          cmd.asrc = A_DOT;
          cmd.bsrc = B_DOT;
          if (stat.mul_last) state_nxt = ST_J8;
        end else begin
          // obtuse turn is sharp; degenerate legs never are
          cmd.sharp_ld  = 1'b1;
          cmd.sharp_val = stat.lp_ok && stat.ln_ok;
          state_nxt     = ST_K0;
        end
      end
      ST_J8: begin
        cmd.wb   = WB_DOT2;
        cmd.run  = 1'b1;
        cmd.asrc = A_LP2;
        cmd.bsrc = B_LN2;
        if (stat.mul_last) state_nxt = ST_J9;
      end
      ST_J9: begin
        cmd.wb    = WB_PR;
        state_nxt = ST_J10;
      end
      ST_J10: begin
        cmd.run  = 1'b1;
        cmd.asrc = A_PR;
        cmd.bsrc = B_COS2;
        if (stat.mul_last) state_nxt = ST_J11;
      end
      ST_J11: begin
        cmd.sharp_ld  = 1'b1;
        cmd.sharp_val = stat.turn_lt;
        state_nxt     = ST_K0;
      end
      // distance of the pending point from the last kept one
      ST_K0: begin
        cmd.run    = 1'b1;
        cmd.dsel_a = D_PK;
        cmd.dsel_b = D_PK;
        if (stat.mul_last) state_nxt = ST_K1;
      end
      ST_K1: begin
        cmd.run      = 1'b1;
        cmd.acc_add  = 1'b1;
        cmd.dsel_a   = D_PK;
        cmd.dsel_b   = D_PK;
        cmd.comp_rad = 1'b1;
        if (stat.mul_last) state_nxt = ST_K2;
      end
      ST_K2: begin
        cmd.wb   = WB_D2;
        cmd.run  = 1'b1;
        cmd.asrc = A_SP;
        cmd.bsrc = B_SP;
        if (stat.mul_last) state_nxt = ST_K3;
      end
      ST_K3: begin
        if (stat.far) begin
          if (stat.out_free) begin
            cmd.emit  = 1'b1;
            cmd.esrc  = E_PEND;
            cmd.keep  = 1'b1;
            state_nxt = stat.last ? ST_F0 : ST_SHIFT;
          end
        end else begin
          state_nxt = stat.last ? ST_F0 : ST_SHIFT;
        end
      end
      // closing duplicate check against the first point
      ST_L0: begin
        cmd.run    = 1'b1;
        cmd.dsel_a = D_NF;
        cmd.dsel_b = D_NF;
        if (stat.mul_last) state_nxt = ST_L1;
      end
      ST_L1: begin
        cmd.run      = 1'b1;
        cmd.acc_add  = 1'b1;
        cmd.dsel_a   = D_NF;
        cmd.dsel_b   = D_NF;
        cmd.comp_rad = 1'b1;
        if (stat.mul_last) state_nxt = ST_L2;
      end
      ST_L2: begin
        if (stat.dup) begin
          cmd.fin_pending = 1'b1;
          state_nxt       = ST_F0;
        end else begin
          state_nxt = ST_J0;
        end
      end
      // final point against the last kept point
      ST_F0: begin
        cmd.run    = 1'b1;
        cmd.dsel_a = D_NK;
        cmd.dsel_b = D_NK;
        if (stat.mul_last) state_nxt = ST_F1;
      end
      ST_F1: begin
        cmd.run      = 1'b1;
        cmd.acc_add  = 1'b1;
        cmd.dsel_a   = D_NK;
        cmd.dsel_b   = D_NK;
        cmd.comp_rad = 1'b1;
        if (stat.mul_last) state_nxt = ST_F2;
      end
      ST_F2: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.eop   = 1'b1;
          cmd.clear = 1'b1;
          if (stat.moved) begin
            cmd.esrc = E_CUR;
            cmd.keep = 1'b1;
            cmd.fail = (stat.kept_cnt == 2'd0);
          end else begin
            cmd.esrc = E_KEPT;
            cmd.fail = (stat.kept_cnt != 2'd2);
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== sv/apd_datapath.sv =====
// Point store, limb-serial multiplier, comparisons and output register.
module apd_datapath import apd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_addr,
  input  logic [REG_W-1:0]          cfg_wdata,
  input  logic signed [COORD_W-1:0] in_axial,
  input  logic signed [COORD_W-1:0] in_radius,
  input  logic                      in_last,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic signed [COORD_W-1:0] out_axial,
  output logic [RAD_W-1:0]          out_radius,
  output logic                      out_eop,
  output logic                      out_failed,
  input  apd_cmd_t                  cmd,
  output apd_stat_t                 stat
);

  typedef struct packed {
    logic            neg;
    logic [LIMB-1:0] mag;
  } delta_t;

  logic [REG_W-1:0] es_r, fl_r, tf_r;
  point_t           cur_r, first_r, older_r, pend_r, kept_r;
  logic             last_r;
  logic [2:0]       seen_r;
  logic [1:0]       kc_r;
  logic [ACC_W-1:0] acc_r;
  logic [1:0]       ia_r;
  logic             jb_r;
  logic             neg_r;
  logic             sharp_r;
  logic [SQ_W-1:0]  lp2_r, ln2_r, pos_r, nsum_r, d2_r;
  logic [PR_W-1:0]  dot2_r, pr_r;
  logic             ov_r, oeop_r, ofail_r;
  point_t           opt_r;

  point_t           ld_pt;
  logic [COORD_W-1:0] neg_rad;
  delta_t           da, db;
  logic [A_W-1:0]   a_op;
  logic [B_W-1:0]   b_op;
  logic [1:0]       na_m1;
  logic             nb_m1;
  logic [LIMB-1:0]  a_limb, b_limb;
  logic [SQ_W-1:0]  pp;
  logic [ACC_W-1:0] pp_sh, acc_base;
  logic             cnt0, mul_last, wb_en;
  logic [SQ_W-1:0]  dot;
  logic [REG_W-1:0] half, base, quarter, sp;
  point_t           esel;
  logic             out_free;

  function automatic delta_t pdelta(point_t x, point_t y, logic rad);
    logic signed [LIMB-1:0] d;
    delta_t r;
    if (rad) begin
      d = $signed({2'b00, x.rad}) - $signed({2'b00, y.rad});
    end else begin
      d = $signed({x.ax[COORD_W-1], x.ax}) - $signed({y.ax[COORD_W-1], y.ax});
    end
    r.neg = d[LIMB-1];
    r.mag = d[LIMB-1] ? LIMB'(-d) : LIMB'(d);
    return r;
  endfunction

  function automatic delta_t dsel(dsel_t s, point_t o, point_t p, point_t n,
                                  point_t k, point_t f, logic rad);
    delta_t r;
    case (s)
      D_PO:    r = pdelta(p, o, rad);
      D_NP:    r = pdelta(n, p, rad);
      D_PK:    r = pdelta(p, k, rad);
      D_NF:    r = pdelta(n, f, rad);
      D_NK:    r = pdelta(n, k, rad);
      default: r = '0;
    endcase
    return r;
  endfunction

  // input radius: absolute value, saturated
  assign neg_rad = -in_radius;
  always_comb begin
    ld_pt.ax = in_axial;
    if (!in_radius[COORD_W-1]) begin
      ld_pt.rad = in_radius[RAD_W-1:0];
    end else if (neg_rad[COORD_W-1]) begin
      ld_pt.rad = {RAD_W{1'b1}};
    end else begin
      ld_pt.rad = neg_rad[RAD_W-1:0];
    end
  end

  // spacing
  assign half    = {1'b0, es_r[REG_W-1:1]};
  assign base    = (half < fl_r) ? fl_r : half;
  assign quarter = {2'b00, base[REG_W-1:2]};
  assign sp      = sharp_r ? ((quarter < tf_r) ? tf_r : quarter) : base;

  assign dot = pos_r - nsum_r;
  assign da  = dsel(cmd.dsel_a, older_r, pend_r, cur_r, kept_r, first_r, cmd.comp_rad);
  assign db  = dsel(cmd.dsel_b, older_r, pend_r, cur_r, kept_r, first_r, cmd.comp_rad);

  always_comb begin
    case (cmd.asrc)
      A_DELTA: begin a_op = A_W'(da.mag); na_m1 = 2'd0; end
      A_LP2:   begin a_op = A_W'(lp2_r);  na_m1 = 2'd1; end
      A_DOT:   begin a_op = A_W'(dot);    na_m1 = 2'd1; end
      A_PR:    begin a_op = A_W'(pr_r);   na_m1 = 2'd3; end
      A_SP:    begin a_op = A_W'(sp);     na_m1 = 2'd0; end
      default: begin a_op = '0;           na_m1 = 2'd0; end
    endcase
    case (cmd.bsrc)
      B_DELTA: begin b_op = B_W'(db.mag);   nb_m1 = 1'b0; end
      B_LN2:   begin b_op = B_W'(ln2_r);    nb_m1 = 1'b1; end
      B_DOT:   begin b_op = B_W'(dot);      nb_m1 = 1'b1; end
      B_COS2:  begin b_op = B_W'(COS2_Q32); nb_m1 = 1'b0; end
      B_SP:    begin b_op = B_W'(sp);       nb_m1 = 1'b0; end
      default: begin b_op = '0;             nb_m1 = 1'b0; end
    endcase
  end

  // one limb pair per cycle while cmd.run is set, shifted into place
  assign a_limb   = a_op[LIMB*ia_r +: LIMB];
  assign b_limb   = b_op[LIMB*jb_r +: LIMB];
  assign pp       = SQ_W'(a_limb) * SQ_W'(b_limb);
  assign pp_sh    = ACC_W'(pp) << (LIMB * (32'(ia_r) + 32'(jb_r)));
  assign cnt0     = (ia_r == 2'd0) && !jb_r;
  assign mul_last = (ia_r == na_m1) && (jb_r == nb_m1);
  assign acc_base = (cnt0 && !cmd.acc_add) ? '0 : acc_r;
  assign wb_en    = cnt0;

  always_comb begin
    case (cmd.esrc)
      E_CUR:   esel = cur_r;
      E_PEND:  esel = pend_r;
      E_KEPT:  esel = kept_r;
      default: esel = kept_r;
    endcase
  end

  assign out_free = !ov_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      es_r   <= ELEMENT_SIZE_RST;
      fl_r   <= FLOOR_SPACING_RST;
      tf_r   <= TIGHT_FLOOR_RST;
      seen_r <= '0;
      kc_r   <= '0;
      ia_r   <= '0;
      jb_r   <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_ELEMENT_SIZE:  es_r <= cfg_wdata;
          CFG_FLOOR_SPACING: fl_r <= cfg_wdata;
          CFG_TIGHT_FLOOR:   tf_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.run) begin
        if (mul_last) begin
          ia_r <= '0;
          jb_r <= 1'b0;
        end else if (jb_r == nb_m1) begin
          ia_r <= ia_r + 2'd1;
          jb_r <= 1'b0;
        end else begin
          jb_r <= 1'b1;
        end
      end
      if (cmd.emit) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
      if (cmd.init_first) begin
        kc_r   <= 2'd1;
        seen_r <= 3'd1;
      end
      if (cmd.shift && seen_r < 3'd4) seen_r <= seen_r + 3'd1;
      if (cmd.keep && kc_r < 2'd2) kc_r <= kc_r + 2'd1;
      if (cmd.clear) begin
        seen_r <= '0;
        kc_r   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_cur) begin
      cur_r  <= ld_pt;
      last_r <= in_last;
    end
    if (cmd.fin_pending) cur_r <= pend_r;
    if (cmd.init_first) begin
      first_r <= cur_r;
      pend_r  <= cur_r;
      kept_r  <= cur_r;
    end
    if (cmd.shift) begin
      older_r <= pend_r;
      pend_r  <= cur_r;
    end
    if (cmd.keep) kept_r <= esel;
    if (cmd.run) begin
      acc_r <= acc_base + pp_sh;
      if (cnt0) neg_r <= da.neg ^ db.neg;
    end
    if (cmd.turn_clr) begin
      pos_r  <= '0;
      nsum_r <= '0;
    end
    if (cmd.sharp_ld) sharp_r <= cmd.sharp_val;
    if (wb_en) begin
      case (cmd.wb)
        WB_LP2:    lp2_r <= acc_r[SQ_W-1:0];
        WB_LN2:    ln2_r <= acc_r[SQ_W-1:0];
        WB_POSNEG: begin
          if (neg_r) nsum_r <= nsum_r + acc_r[SQ_W-1:0];
          else       pos_r  <= pos_r + acc_r[SQ_W-1:0];
        end
        WB_DOT2:   dot2_r <= acc_r[PR_W-1:0];
        WB_PR:     pr_r   <= acc_r[PR_W-1:0];
        WB_D2:     d2_r   <= acc_r[SQ_W-1:0];
        default: ;
      endcase
    end
    if (cmd.emit) begin
      opt_r   <= esel;
      oeop_r  <= cmd.eop;
      ofail_r <= cmd.fail;
    end
  end

  always_comb begin
    stat.seen       = seen_r;
    stat.kept_cnt   = kc_r;
    stat.last       = last_r;
    stat.mul_last   = mul_last;
    stat.out_free   = out_free;
    stat.lp_ok      = lp2_r > SQ_W'(EPS_LEN_SQ);
    stat.ln_ok      = ln2_r > SQ_W'(EPS_LEN_SQ);
    stat.pos_lt_neg = pos_r < nsum_r;
    stat.turn_lt    = ACC_W'({dot2_r, 32'd0}) < acc_r;
    stat.far        = ACC_W'(d2_r) >= acc_r;
    stat.dup        = acc_r < ACC_W'(EPS_DUP_SQ);
    stat.moved      = acc_r > ACC_W'(EPS_LEN_SQ);
  end

  assign out_valid  = ov_r;
  assign out_axial  = opt_r.ax;
  assign out_radius = opt_r.rad;
  assign out_eop    = oeop_r;
  assign out_failed = ofail_r;

endmodule

// ===== sv/apd_checker.sv =====
// Port-level assertions of the decimator, bound to the top level.
module apd_port_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_eop,
  input logic out_failed
);

  // a waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // failure is only flagged on the closing result
  a_fail_eop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_failed |-> out_eop)
    else $error("failed set on a non-final result");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

endmodule

bind adaptive_profile_decimator_top apd_port_checker u_apd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_pt.valid),
  .in_ready   (in_pt.ready),
  .out_valid  (out_pt.valid),
  .out_ready  (out_pt.ready),
  .out_eop    (out_pt.end_of_profile),
  .out_failed (out_pt.failed)
);

// ===== dv/apd_checker.sv =====
// Checker for the profile decimator: watches both channels, predicts kept points and compares.
module apd_checker import apd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_addr,
  input  logic [REG_W-1:0] cfg_wdata,
  apd_in_if                in_pt,
  apd_out_if               out_pt,
  output int               fail_count,
  output int               pending_count,
  output int               kept_seen,
  output int               profiles_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [COORD_W-1:0] ax;
    logic [RAD_W-1:0]          rad;
    logic                      eop;
    logic                      fail;
  } kept_t;

  typedef struct {
    longint ax;
    longint rad;
  } pt_t;

  localparam longint RADIUS_MAX = 64'sd2147483647;
  localparam logic [255:0] COS2 = 256'(COS2_Q32);

  logic [REG_W-1:0] elem_size, floor_sp, tight_sp;
  pt_t first_pt, older_pt, pend_pt, kept_pt;
  int  n_seen, n_kept;
  kept_t kept_q[$];

  function automatic logic [127:0] sq_len(pt_t a, pt_t b);
    longint dx, dy;
    logic [127:0] mx, my;
    dx = a.ax - b.ax;
    dy = a.rad - b.rad;
    mx = dx < 0 ? -dx : dx;
    my = dy < 0 ? -dy : dy;
    return mx * mx + my * my;
  endfunction

  function automatic logic is_sharp(pt_t o, pt_t p, pt_t n);
    logic [255:0] lp2, ln2, eps2, dot, lhs, rhs;
    logic signed [127:0] d;
    lp2  = sq_len(p, o);
    ln2  = sq_len(n, p);
    eps2 = 256'(EPS_LEN) * 256'(EPS_LEN);
    if (lp2 <= eps2 || ln2 <= eps2) return 1'b0;
    d = 128'(p.ax - o.ax) * 128'(n.ax - p.ax) + 128'(p.rad - o.rad) * 128'(n.rad - p.rad);
    if (d < 0) return 1'b1;
    dot = 256'(d);
    lhs = (dot * dot) << 32;
    rhs = lp2 * ln2 * COS2;
    return lhs < rhs;
  endfunction

  task automatic push(pt_t q, logic eop, logic fl);
    kept_t e;
    e.ax   = q.ax[COORD_W-1:0];
    e.rad  = q.rad[RAD_W-1:0];
    e.eop  = eop;
    e.fail = fl;
    kept_q.insert(kept_q.size(), e);
  endtask

  task automatic keep_pt(pt_t q);
    kept_pt = q;
    if (n_kept < 2) n_kept++;
  endtask

  task automatic judge(pt_t o, pt_t p, pt_t n);
    logic [63:0] sp;
    sp = elem_size >> 1;
    if (sp < floor_sp) sp = floor_sp;
    if (is_sharp(o, p, n)) begin
      sp = sp >> 2;
      if (sp < tight_sp) sp = tight_sp;
    end
    if (sq_len(p, kept_pt) >= 128'(sp) * 128'(sp)) begin
      keep_pt(p);
      push(p, 1'b0, 1'b0);
    end
  endtask

  task automatic clear_profile();
    first_pt = '{0, 0};
    older_pt = '{0, 0};
    pend_pt  = '{0, 0};
    kept_pt  = '{0, 0};
    n_seen   = 0;
    n_kept   = 0;
  endtask

  task automatic predict(logic signed [COORD_W-1:0] ax, logic signed [COORD_W-1:0] ra,
                         logic last);
    pt_t cur, fin;
    cur.ax  = ax;
    cur.rad = ra;
    if (cur.rad < 0) cur.rad = -cur.rad;
    if (cur.rad > RADIUS_MAX) cur.rad = RADIUS_MAX;
    if (n_seen == 0) begin
      first_pt = cur;
      pend_pt  = cur;
      kept_pt  = cur;
      n_kept   = 1;
      n_seen   = 1;
      push(cur, last, last);
      if (last) clear_profile();
      return;
    end
    if (!last) begin
      if (n_seen >= 2) judge(older_pt, pend_pt, cur);
      older_pt = pend_pt;
      pend_pt  = cur;
      if (n_seen < 4) n_seen++;
      return;
    end
    if (n_seen < 3) begin
      push(kept_pt, 1'b1, 1'b1);
      clear_profile();
      return;
    end
    // drop a closing duplicate of the first point
    if (sq_len(cur, first_pt) < 128'(EPS_DUP) * 128'(EPS_DUP)) begin
      fin = pend_pt;
    end else begin
      judge(older_pt, pend_pt, cur);
      fin = cur;
    end
    if (sq_len(fin, kept_pt) > 128'(EPS_LEN) * 128'(EPS_LEN)) begin
      keep_pt(fin);
      push(fin, 1'b1, n_kept < 2);
    end else begin
      push(kept_pt, 1'b1, n_kept < 2);
    end
    clear_profile();
  endtask

  always @(posedge clk) begin
    kept_t e;
    if (!rst_n) begin
      elem_size  <= ELEMENT_SIZE_RST;
      floor_sp   <= FLOOR_SPACING_RST;
      tight_sp   <= TIGHT_FLOOR_RST;
      clear_profile();
      kept_q.delete();
      fail_count    <= 0;
      kept_seen     <= 0;
      profiles_seen <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_ELEMENT_SIZE:  elem_size <= cfg_wdata;
          CFG_FLOOR_SPACING: floor_sp  <= cfg_wdata;
          CFG_TIGHT_FLOOR:   tight_sp  <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_pt.valid && in_pt.ready)
        predict(in_pt.point_axial, in_pt.point_radius, in_pt.last_point);
      if (out_pt.valid && out_pt.ready) begin
        kept_seen <= kept_seen + 1;
        if (kept_q.size() == 0) begin
          $error("unexpected kept point ax=%0d rad=%0d", out_pt.kept_axial,
                 out_pt.kept_radius);
          fail_count <= fail_count + 1;
        end else begin
          e = kept_q.pop_front();
          if (e.eop) profiles_seen <= profiles_seen + 1;
          if (out_pt.kept_axial !== e.ax || out_pt.kept_radius !== e.rad ||
              out_pt.end_of_profile !== e.eop || out_pt.failed !== e.fail) begin
            if (out_pt.kept_axial !== e.ax)
              $error("kept_axial expected %0d actual %0d", e.ax, out_pt.kept_axial);
            if (out_pt.kept_radius !== e.rad)
              $error("kept_radius expected %0d actual %0d", e.rad, out_pt.kept_radius);
            if (out_pt.end_of_profile !== e.eop)
              $error("end_of_profile expected %0b actual %0b", e.eop,
                     out_pt.end_of_profile);
            if (out_pt.failed !== e.fail)
              $error("failed expected %0b actual %0b", e.fail, out_pt.failed);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  assign pending_count = kept_q.size();
endmodule

// ===== dv/adaptive_profile_decimator_top_test.sv =====
// Stimulus and verdict for the adaptive profile decimator.
module adaptive_profile_decimator_top_test;
  import apd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_addr = CFG_ELEMENT_SIZE;
  logic [REG_W-1:0] cfg_wdata = '0;
  int               fail_count, pending_count, kept_seen, profiles_seen;
  int               sent = 0;
  logic             calm = 1'b0;
  logic signed [31:0] cur_ax, cur_rad;

  apd_in_if  in_pt();
  apd_out_if out_pt();

  adaptive_profile_decimator_top i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata), .in_pt(in_pt.sink), .out_pt(out_pt.source)
  );

  apd_checker i_checker (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata), .in_pt(in_pt), .out_pt(out_pt),
    .fail_count(fail_count), .pending_count(pending_count),
    .kept_seen(kept_seen), .profiles_seen(profiles_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    in_pt.valid        = 1'b0;
    in_pt.point_axial  = '0;
    in_pt.point_radius = '0;
    in_pt.last_point   = 1'b0;
    out_pt.ready       = 1'b0;
  end

  // receiver stalls at random, none once calm
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 3);
        out_pt.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_pt.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // valid stays high between back-to-back requests; drop it only to idle
  task automatic send_point(logic signed [31:0] ax, logic signed [31:0] ra, logic last);
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 3);
      in_pt.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_pt.valid        <= 1'b1;
    in_pt.point_axial  <= ax;
    in_pt.point_radius <= ra;
    in_pt.last_point   <= last;
    do @(posedge clk); while (!in_pt.ready);
    sent++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [REG_W-1:0] val);
    int n;
    n = 0;
    in_pt.valid <= 1'b0;
    while (pending_count != 0 && n < 20000) begin
      @(posedge clk);
      n++;
    end
    repeat (40) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // well-formed profile: a walk with random steps, sometimes sharp turns, sometimes closed
  task automatic send_profile(int len, int step);
    logic signed [31:0] ax0, r0;
    int dx, dy;
    ax0 = $urandom_range(0, 1 << 22) - (1 << 21);
    r0  = $urandom_range(0, 1 << 22) - (1 << 21);
    cur_ax = ax0;
    cur_rad = r0;
    dx = $urandom_range(0, step);
    dy = $urandom_range(0, step) - step / 2;
    for (int i = 0; i < len; i++) begin
      if (i == len - 1 && $urandom_range(0, 2) == 0) begin
        send_point(ax0 + $signed($urandom_range(0, 60)) - 30, r0, 1'b1);
      end else begin
        send_point(cur_ax, cur_rad, i == len - 1);
      end
      if ($urandom_range(0, 4) == 0) begin
        dx = $urandom_range(0, step) - step / 2;
        dy = $urandom_range(0, step) - step / 2;
      end
      if ($urandom_range(0, 9) == 0) begin
        dx = 0;
        dy = 0;
      end
      cur_ax  = cur_ax + dx;
      cur_rad = cur_rad + dy;
    end
  endtask

  initial begin
    logic [REG_W-1:0] vals[3];
    int len;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes, short profiles, duplicates, reversal
    send_point(32'sh7fffffff, 32'sh80000000, 1'b1);
    send_point(32'sh80000000, 32'sh7fffffff, 1'b0);
    send_point(32'sh80000000, 32'sh7fffffff, 1'b1);
    send_point(0, 0, 1'b0);
    send_point(1000, -5000, 1'b0);
    send_point(2000, 0, 1'b1);
    send_point(0, 0, 1'b0);
    send_point(40000, 0, 1'b0);
    send_point(80000, 0, 1'b0);
    send_point(40000, 0, 1'b0);
    send_point(40000, 50000, 1'b0);
    send_point(10, 0, 1'b1);
    send_point(32'sh7fffffff, 32'sh7fffffff, 1'b0);
    send_point(32'sh80000000, 32'sh80000000, 1'b0);
    send_point(32'sh7fffffff, 0, 1'b0);
    send_point(32'sh80000000, 32'sh7fffffff, 1'b0);
    send_point(32'sh80000000, 32'sh80000000, 1'b1);
    send_point(5, 5, 1'b0);
    send_point(5, 5, 1'b0);
    send_point(5, 5, 1'b0);
    send_point(5, 6, 1'b1);

    write_reg(CFG_ELEMENT_SIZE, '0);
    write_reg(CFG_FLOOR_SPACING, '0);
    write_reg(CFG_TIGHT_FLOOR, '0);
    send_profile(6, 3000);
    write_reg(CFG_ELEMENT_SIZE, '1);
    write_reg(CFG_FLOOR_SPACING, '1);
    write_reg(CFG_TIGHT_FLOOR, '1);
    send_profile(5, 1 << 30);

    for (int phase = 0; phase < 8; phase++) begin
      vals[0] = $urandom_range(2000, 200000);
      vals[1] = $urandom_range(0, 8000);
      vals[2] = $urandom_range(0, 4000);
      if (phase == 7) begin
        vals = '{ELEMENT_SIZE_RST, FLOOR_SPACING_RST, TIGHT_FLOOR_RST};
      end
      write_reg(CFG_ELEMENT_SIZE, vals[0]);
      write_reg(CFG_FLOOR_SPACING, vals[1]);
      write_reg(CFG_TIGHT_FLOOR, vals[2]);
      if (phase == 6) calm = 1'b1;
      while (sent < 160 * (phase + 1) + 60) begin
        case ($urandom_range(0, 9))
          0: begin
            // noise, full-range points
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
              send_point($urandom, $urandom, i == len - 1);
          end
          1: send_profile($urandom_range(1, 3), 40000);
          2: send_profile($urandom_range(4, 12), 1 << 28);
          default: send_profile($urandom_range(4, 20), $urandom_range(100, 120000));
        endcase
      end
    end

    in_pt.valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Sent %0d points over 11 register settings;", sent);
    $display("checked %0d kept points in %0d profiles.", kept_seen, profiles_seen);
    if (fail_count == 0 && pending_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
